FILE: src/transfer_function_lerp_table_core_macros.svh
// Assertion macros for the transfer function core.
// Used by the top level only; no other dependencies.
`ifndef TRANSFER_FUNCTION_LERP_TABLE_CORE_MACROS_SVH
`define TRANSFER_FUNCTION_LERP_TABLE_CORE_MACROS_SVH
`define TFL_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TFL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/tfl_pkg.sv
// Shared types and constants for the transfer function core.
// No dependencies.
package tfl_pkg;
   localparam int MaxNodes = 16;
   localparam int IdxW = $clog2(MaxNodes);
   localparam int CntW = $clog2(MaxNodes + 1);

   typedef enum logic [1:0] {
      PROP_SPEC  = 2'd0,
      PROP_DIFF  = 2'd1,
      PROP_ROUGH = 2'd2,
      PROP_ALPHA = 2'd3
   } prop_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SHIFT_RD, ST_SHIFT_WR, ST_WRITE,
      ST_SCAN_RD, ST_SCAN_CHK, ST_DIV, ST_VAL_RD, ST_MIX, ST_DONE
   } state_type;

   typedef struct packed {
      logic [16:0] level;
      logic [47:0] spec;
      logic [47:0] diff;
      logic [31:0] ra;
   } node_type;

   // Divider control / status
   typedef struct packed {
      logic        start;
      logic [16:0] num;
      logic [16:0] den;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quo;
   } div_sts_type;
endpackage

FILE: src/transfer_function_lerp_table_core.sv
// Transfer function core: sorted node table with linear interpolation.
// Insert: nodes above the key are read and shifted up, then the new node is written;
// a full table is rejected. Lookup: scan for the bracketing pair, divide for t, fetch
// the pair, mix one channel (rough, alpha) or three. Result beat on rsp_valid the cycle
// after ST_DONE; busy stays high through it, so no request is taken; receiver cannot stall.
// Synchronous active-high reset empties the table; node store is not cleared.
module transfer_function_lerp_table_core
   import tfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [16:0] req_level,
   input  logic [15:0] req_spec_r,
   input  logic [15:0] req_spec_g,
   input  logic [15:0] req_spec_b,
   input  logic [15:0] req_diff_r,
   input  logic [15:0] req_diff_g,
   input  logic [15:0] req_diff_b,
   input  logic [15:0] req_rough,
   input  logic [15:0] req_opacity,
   input  logic [1:0]  req_property_req,
   output logic        rsp_valid,
   output logic [15:0] rsp_chan_a,
   output logic [15:0] rsp_chan_b,
   output logic [15:0] rsp_chan_c,
   output logic        rsp_found,
   output logic        rsp_rejected
);
   `include "transfer_function_lerp_table_core_macros.svh"

   state_type   state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic        op_ff, op_in;
   logic [16:0] key_ff, key_in;
   node_type    new_ff, new_in;
   prop_type    prop_ff, prop_in;
   logic [16:0] lo_ff, lo_in;
   logic        have_lo_ff, have_lo_in;
   logic [15:0] t_ff, t_in;
   logic [47:0] pa_ff, pa_in;
   logic        phase_ff, phase_in;
   logic [1:0]  mix_ff, mix_in;
   logic [15:0] ra_ff, rb_ff, rc_ff, ra_in, rb_in, rc_in;
   logic        fnd_ff, fnd_in, rej_ff, rej_in, vld_ff, vld_in;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   node_type        wr_data, rd_data;
   div_ctl_type     dctl;
   div_sts_type     dsts;
   logic [47:0]     sel_q;
   logic [15:0]     mu_a, mu_b;
   logic [32:0]     mix_prod;

   tfl_mem u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   tfl_div u_div (.clock, .reset, .ctl(dctl), .sts(dsts));

   always_comb begin
      unique case (prop_ff)
         PROP_SPEC:  sel_q = rd_data.spec;
         PROP_DIFF:  sel_q = rd_data.diff;
         PROP_ROUGH: sel_q = {rd_data.ra[31:16], 32'd0};
         PROP_ALPHA: sel_q = {rd_data.ra[15:0], 32'd0};
         default:    sel_q = '0;
      endcase
   end

   // shared mixer: a*(65536-t) + b*t = a*65536 + (b-a)*t
   always_comb begin
      unique case (mix_ff)
         2'd0:    begin mu_a = pa_ff[47:32]; mu_b = sel_q[47:32]; end
         2'd1:    begin mu_a = pa_ff[31:16]; mu_b = sel_q[31:16]; end
         default: begin mu_a = pa_ff[15:0];  mu_b = sel_q[15:0];  end
      endcase
      mix_prod = {1'b0, mu_a, 16'd0} - ({17'd0, mu_a} * {17'd0, t_ff})
                 + ({17'd0, mu_b} * {17'd0, t_ff});
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      new_in     = new_ff;
      prop_in    = prop_ff;
      lo_in      = lo_ff;
      have_lo_in = have_lo_ff;
      t_in       = t_ff;
      pa_in      = pa_ff;
      phase_in   = phase_ff;
      mix_in     = mix_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      rc_in      = rc_ff;
      fnd_in     = fnd_ff;
      rej_in     = rej_ff;
      vld_in     = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff[IdxW-1:0];
      wr_data    = new_ff;
      rd_addr    = '0;
      dctl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               op_in   = req_op;
               key_in  = req_level;
               prop_in = prop_type'(req_property_req);
               new_in  = '{level: req_level,
                           spec: {req_spec_r, req_spec_g, req_spec_b},
                           diff: {req_diff_r, req_diff_g, req_diff_b},
                           ra: {req_rough, req_opacity}};
               ra_in = '0; rb_in = '0; rc_in = '0;
               fnd_in = 1'b0; rej_in = 1'b0;
               pos_in = count_ff;
               have_lo_in = 1'b0;
               if (req_op == OP_INSERT) begin
                  if (count_ff == CntW'(MaxNodes)) begin
                     rej_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = (count_ff == '0) ? ST_WRITE : ST_SHIFT_RD;
                  end
               end else begin
                  pos_in   = '0;
                  state_in = (count_ff < CntW'(2)) ? ST_DONE : ST_SCAN_RD;
               end
            end
         end
         ST_SHIFT_RD: begin
            rd_addr  = IdxW'(pos_ff - CntW'(1));
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            if (rd_data.level > key_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = pos_ff - CntW'(1);
               state_in = (pos_ff == CntW'(1)) ? ST_WRITE : ST_SHIFT_RD;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CntW'(1);
            state_in = ST_DONE;
         end
         ST_SCAN_RD: begin
            rd_addr  = pos_ff[IdxW-1:0];
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (have_lo_ff && key_ff >= lo_ff && key_ff < rd_data.level) begin
               dctl.start = 1'b1;
               dctl.num   = key_ff - lo_ff;
               dctl.den   = rd_data.level - lo_ff;
               pos_in     = pos_ff - CntW'(1);
               state_in   = ST_DIV;
            end else if (pos_ff == count_ff - CntW'(1)) begin
               state_in = ST_DONE;
            end else begin
               lo_in      = rd_data.level;
               have_lo_in = 1'b1;
               pos_in     = pos_ff + CntW'(1);
               state_in   = ST_SCAN_RD;
            end
         end
         ST_DIV: begin
            if (dsts.done) begin
               t_in     = dsts.quo;
               phase_in = 1'b0;
               state_in = ST_VAL_RD;
            end
         end
         ST_VAL_RD: begin
            rd_addr  = pos_ff[IdxW-1:0];
            mix_in   = 2'd0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            rd_addr = pos_ff[IdxW-1:0];
            if (!phase_ff) begin
               pa_in    = sel_q;
               phase_in = 1'b1;
               pos_in   = pos_ff + CntW'(1);
               state_in = ST_VAL_RD;
            end else begin
               unique case (mix_ff)
                  2'd0:    ra_in = mix_prod[31:16];
                  2'd1:    rb_in = mix_prod[31:16];
                  default: rc_in = mix_prod[31:16];
               endcase
               mix_in = mix_ff + 2'd1;
               if (mix_ff == 2'd2 || prop_ff == PROP_ROUGH || prop_ff == PROP_ALPHA) begin
                  fnd_in   = 1'b1;
                  state_in = ST_DONE;
                  if (prop_ff == PROP_ALPHA) begin
                     rb_in = mix_prod[31:16];
                     rc_in = mix_prod[31:16];
                  end
               end
            end
         end
         ST_DONE: begin
            vld_in   = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
      end
      pos_ff     <= pos_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      new_ff     <= new_in;
      prop_ff    <= prop_in;
      lo_ff      <= lo_in;
      have_lo_ff <= have_lo_in;
      t_ff       <= t_in;
      pa_ff      <= pa_in;
      phase_ff   <= phase_in;
      mix_ff     <= mix_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      rc_ff      <= rc_in;
      fnd_ff     <= fnd_in;
      rej_ff     <= rej_in;
   end

   assign busy         = (state_ff != ST_IDLE) || vld_ff;
   assign rsp_valid    = vld_ff;
   assign rsp_chan_a   = ra_ff;
   assign rsp_chan_b   = rb_ff;
   assign rsp_chan_c   = rc_ff;
   assign rsp_found    = fnd_ff;
   assign rsp_rejected = rej_ff;

   `TFL_ASSERT_IMPL(a_count_bound, clock, reset, count_ff <= CntW'(MaxNodes), "count overflow")
   `TFL_ASSERT_IMPL(a_flags_excl, clock, reset, rsp_valid |-> !(rsp_found && rsp_rejected), "found and rejected")
   `TFL_ASSERT_IMPL(a_insert_zero, clock, reset, (rsp_valid && op_ff == OP_INSERT) |-> (!rsp_found && rsp_chan_a == 16'd0), "insert result")
   `TFL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "valid after reset")
endmodule

FILE: src/tfl_div.sv
// Restoring divider: quo = floor(num * 65536 / den), one bit per cycle.
// Depends on tfl_pkg.
module tfl_div
   import tfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts
);
   logic [17:0] rem_ff, rem_in;
   logic [16:0] den_ff, den_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [18:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, 1'b0} - {2'b0, den_ff};
      if (ctl.start) begin
         rem_in  = {1'b0, ctl.num};
         den_in  = ctl.den;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[18]) begin
            rem_in = trial[17:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[16:0], 1'b0};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;
endmodule

FILE: src/tfl_mem.sv
// Node store: one write port, one registered read port.
// Depends on tfl_pkg.
module tfl_mem
   import tfl_pkg::*;
(
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  node_type        wr_data,
   input  logic [IdxW-1:0] rd_addr,
   output node_type        rd_data
);
   node_type mem_ff [MaxNodes];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: test/transfer_function_lerp_table_core_test.sv
// Self-checking bench for the transfer function core: inserts and lookups against
// a behavioural predictor held in a small scoreboard class. Depends on tfl_pkg.
module transfer_function_lerp_table_core_test
   import tfl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] a, b, c;
      logic        found, rej;
   } lerp_result_type;

   class lerp_table_board;
      logic [16:0] lvl [MaxNodes];
      logic [47:0] spc [MaxNodes];
      logic [47:0] dif [MaxNodes];
      logic [31:0] rga [MaxNodes];
      int count;
      lerp_result_type pending[$];
      int errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function logic [15:0] mix(logic [15:0] lo_v, logic [15:0] hi_v, logic [16:0] t);
         logic [33:0] s;
         s = lo_v * (34'd65536 - t) + hi_v * t;
         return s[31:16];
      endfunction

      function void note_beat(logic op, logic [16:0] key, logic [15:0] f [8],
                              logic [1:0] prop);
         lerp_result_type r;
         int pos;
         logic [16:0] t, lo, hi;
         logic [47:0] p, q;
         r = '{default: '0};
         if (op == OP_INSERT) begin
            if (count >= MaxNodes) begin
               r.rej = 1;
            end else begin
               pos = count;
               while (pos > 0 && lvl[pos-1] > key) begin
                  lvl[pos] = lvl[pos-1]; spc[pos] = spc[pos-1];
                  dif[pos] = dif[pos-1]; rga[pos] = rga[pos-1];
                  pos--;
               end
               lvl[pos] = key;
               spc[pos] = {f[0], f[1], f[2]};
               dif[pos] = {f[3], f[4], f[5]};
               rga[pos] = {f[6], f[7]};
               count++;
            end
         end else begin
            for (int i = 0; i + 1 < count; i++) begin
               lo = lvl[i]; hi = lvl[i+1];
               if (key >= lo && key < hi) begin
                  t = ({17'd0, key - lo} << 16) / (hi - lo);
                  if (prop == PROP_SPEC || prop == PROP_DIFF) begin
                     p = (prop == PROP_SPEC) ? spc[i] : dif[i];
                     q = (prop == PROP_SPEC) ? spc[i+1] : dif[i+1];
                     r.a = mix(p[47:32], q[47:32], t);
                     r.b = mix(p[31:16], q[31:16], t);
                     r.c = mix(p[15:0], q[15:0], t);
                  end else if (prop == PROP_ROUGH) begin
                     r.a = mix(rga[i][31:16], rga[i+1][31:16], t);
                  end else begin
                     r.a = mix(rga[i][15:0], rga[i+1][15:0], t);
                     r.b = r.a; r.c = r.a;
                  end
                  r.found = 1;
                  break;
               end
            end
         end
         pending = {pending, r};
      endfunction

      function void check_beat(lerp_result_type got);
         lerp_result_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat");
            return;
         end
         e = pending.pop_front();
         if (got.a !== e.a || got.b !== e.b || got.c !== e.c || got.found !== e.found
             || got.rej !== e.rej) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp %h %h %h f%b r%b got %h %h %h f%b r%b",
                        e.a, e.b, e.c, e.found, e.rej, got.a, got.b, got.c,
                        got.found, got.rej);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, busy;
   logic req_op = 0;
   logic [16:0] req_level = 0;
   logic [15:0] req_spec_r = 0, req_spec_g = 0, req_spec_b = 0;
   logic [15:0] req_diff_r = 0, req_diff_g = 0, req_diff_b = 0;
   logic [15:0] req_rough = 0, req_opacity = 0;
   logic [1:0]  req_property_req = 0;
   logic rsp_valid, rsp_found, rsp_rejected;
   logic [15:0] rsp_chan_a, rsp_chan_b, rsp_chan_c;

   lerp_table_board board = new();
   int idle_cycles = 0;
   int burst_left = 0;

   transfer_function_lerp_table_core dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            board.check_beat('{rsp_chan_a, rsp_chan_b, rsp_chan_c, rsp_found, rsp_rejected});
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("transfer_function_lerp_table_core_test: errors");
            $finish;
         end
      end
   end

   task automatic send_beat(logic op, logic [16:0] key, logic [1:0] prop);
      logic [15:0] f [8];
      foreach (f[k]) f[k] = 16'($urandom);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_op = op; req_level = key; req_property_req = prop;
      {req_spec_r, req_spec_g, req_spec_b} = {f[0], f[1], f[2]};
      {req_diff_r, req_diff_g, req_diff_b} = {f[3], f[4], f[5]};
      {req_rough, req_opacity} = {f[6], f[7]};
      start = 1;
      do @(posedge clock); while (busy);
      board.note_beat(op, key, f, prop);
      @(negedge clock);
      start = 0;
   endtask

   function automatic logic [16:0] rand_key();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(0, 131071));
         3: return 17'($urandom_range(0, 15) * 4096);
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // empty and single-node tables, equal levels, extremes, overfill
      send_beat(OP_LOOKUP, 17'd100, PROP_SPEC);
      send_beat(OP_INSERT, 17'd0, PROP_SPEC);
      send_beat(OP_LOOKUP, 17'd0, PROP_DIFF);
      send_beat(OP_INSERT, 17'd65536, PROP_ALPHA);
      send_beat(OP_INSERT, 17'd32768, PROP_SPEC);
      send_beat(OP_INSERT, 17'd32768, PROP_SPEC);
      send_beat(OP_INSERT, 17'h1FFFF, PROP_SPEC);
      for (int p = 0; p < 4; p++) begin
         send_beat(OP_LOOKUP, 17'd32768, 2'(p));
         send_beat(OP_LOOKUP, 17'd65535, 2'(p));
      end
      send_beat(OP_LOOKUP, 17'd0, PROP_ALPHA);
      send_beat(OP_LOOKUP, 17'h1FFFF, PROP_SPEC);
      send_beat(OP_LOOKUP, 17'h10000, PROP_ROUGH);
      send_beat(OP_LOOKUP, 17'h1FFFE, PROP_DIFF);
      repeat (12) send_beat(OP_INSERT, rand_key(), PROP_SPEC);
      // random: mostly lookups, with inserts that the full table rejects
      for (int n = 0; n < 1200; n++) begin
         if ($urandom_range(0, 3) == 0) send_beat(OP_INSERT, rand_key(), 2'($urandom));
         else send_beat(OP_LOOKUP, rand_key(), 2'($urandom));
      end
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) $display("transfer_function_lerp_table_core_test: clean");
      else $display("transfer_function_lerp_table_core_test: errors");
      $finish;
   end
endmodule
